FILE: design/qts_pkg.sv
// qts_pkg: shared types and constants of the quintic trajectory sampler
// used by quintic_trajectory_sampler and qts_checker, no dependencies
package qts_pkg;

   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START    = 2'd0,
      CSR_END      = 2'd1,
      CSR_DURATION = 2'd2,
      CSR_COUNT    = 2'd3
   } csr_addr_type;

   localparam int MAX_SAMPLES = 1024;
   localparam int IDX_W      = 10;
   localparam int CNT_W      = 11;
   localparam int TF_W       = 31;
   localparam int TFSQ_W     = 2 * TF_W;
   localparam int SHAPE_FRAC = 24;
   localparam int S_W        = SHAPE_FRAC + 1;
   localparam int SQ_W       = 2 * S_W;
   // reciprocal of N-1 scaled by 2^RCP_SHIFT, plus one, exact for idx*2^24
   localparam int RCP_SHIFT  = 45;
   localparam int RCP_W      = RCP_SHIFT + 1;
   localparam int RCP_STEPS  = RCP_SHIFT + 1;
   localparam int RCP_CNT_W  = $clog2(RCP_STEPS);
   localparam int B_W        = IDX_W + RCP_W;
   localparam int G_W        = 36;
   localparam int H_W        = 29;
   localparam int D_W        = 33;
   localparam int MP_W       = D_W + H_W;
   localparam int P_W        = MP_W - SHAPE_FRAC;
   localparam int ADIV1_BITS = 34;
   localparam int DIV_BITS   = 31;
   localparam int CHAIN      = ADIV1_BITS + 1 + DIV_BITS;
   localparam int FRONT      = 8;

   localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

   typedef struct packed {
      logic                   clamped;
      logic signed [31:0]     position;
      logic                   v_neg;
      logic                   v_sat;
      logic                   a_neg;
      logic                   a_sat;
      logic [TF_W-1:0]        v_rem;
      logic [DIV_BITS-1:0]    v_quo;
      logic [TF_W-1:0]        a_rem;
      logic [ADIV1_BITS-1:0]  a_quo;
   } chain_type;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [31:0] acceleration;
      logic               index_clamped;
   } result_type;

endpackage

FILE: design/quintic_trajectory_sampler.sv
// channel  | ports                                      | moves
// req      | req_valid req_ready req_sample_index       | one sample index per word
// rsp      | rsp_valid rsp_ready rsp_position ...       | position, velocity, accel
// csr      | csr_valid csr_ready csr_index csr_data     | one register write per word
//
// one word per cycle while the result buffer has room and no reciprocal is being
// formed; depth is set by the long-division chains, run side by side (velocity,
// acceleration twice through the duration), at one quotient bit per stage
// after reset and after every csr write req_ready stays low while the serial
// divider forms the reciprocal of N-1
// a two-word result buffer sits at the output; when it is full the whole
// pipeline holds, nothing is dropped or repeated
module quintic_trajectory_sampler (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [qts_pkg::IDX_W-1:0]             req_sample_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [31:0]                    rsp_position,
   output logic signed [31:0]                    rsp_velocity,
   output logic signed [31:0]                    rsp_acceleration,
   output logic                                  rsp_index_clamped,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [qts_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [31:0]                           csr_data
);
   import qts_pkg::*;

   localparam int NV = FRONT + CHAIN + 1;

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (v < CNT_W'(2)) r = CNT_W'(2);
      else if (32'(v) > MAX_SAMPLES) r = CNT_W'(MAX_SAMPLES);
      else r = v;
      return r;
   endfunction

   function automatic logic [S_W-1:0] qmul(input logic [S_W-1:0] a, input logic [S_W-1:0] b);
      logic [SQ_W-1:0] p;
      p = SQ_W'(a) * SQ_W'(b);
      return p[SHAPE_FRAC +: S_W];
   endfunction

   // one restoring step: {quotient bit, new remainder}
   function automatic logic [TF_W:0] div_step(input logic [TF_W-1:0] rem,
                                              input logic bit_in,
                                              input logic [TF_W-1:0] dv);
      logic [TF_W:0] t;
      logic          ge;
      t  = {rem, bit_in};
      ge = t >= {1'b0, dv};
      return {ge, ge ? TF_W'(t - {1'b0, dv}) : t[TF_W-1:0]};
   endfunction

   // configuration
   logic signed [31:0]    start_ff, end_ff;
   logic [TF_W-1:0]       tf_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [TFSQ_W-1:0]     tfsq_ff;
   logic signed [D_W-1:0] d_ff;
   logic                  csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= '0;
         tf_ff    <= TF_W'(65536);
         count_ff <= clamp_count(CNT_W'(200));
      end else if (csr_write) begin
         case (csr_addr_type'(csr_index))
            CSR_START:    start_ff <= csr_data;
            CSR_END:      end_ff   <= csr_data;
            CSR_DURATION: tf_ff    <= (csr_data[TF_W-1:0] == '0) ? TF_W'(1)
                                                                 : csr_data[TF_W-1:0];
            CSR_COUNT:    count_ff <= clamp_count(csr_data[CNT_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      tfsq_ff <= TFSQ_W'(tf_ff) * TFSQ_W'(tf_ff);
      d_ff    <= D_W'(end_ff) - D_W'(start_ff);
   end

   // serial reciprocal of N-1
   logic                 rcp_busy_ff;
   logic [RCP_CNT_W-1:0] rcp_cnt_ff;
   logic [CNT_W-1:0]     rcp_rem_ff;
   logic [RCP_W-1:0]     rcp_quo_ff, recip_ff;
   logic [CNT_W-1:0]     m_val;
   logic [CNT_W:0]       rcp_t;
   logic                 rcp_ge;

   assign m_val  = count_ff - CNT_W'(1);
   assign rcp_t  = {rcp_rem_ff, rcp_cnt_ff == '0};
   assign rcp_ge = rcp_t >= {1'b0, m_val};

   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         rcp_busy_ff <= 1'b1;
         rcp_cnt_ff  <= '0;
         rcp_rem_ff  <= '0;
      end else if (rcp_busy_ff) begin
         rcp_rem_ff <= rcp_ge ? CNT_W'(rcp_t - {1'b0, m_val}) : rcp_t[CNT_W-1:0];
         rcp_quo_ff <= {rcp_quo_ff[RCP_W-2:0], rcp_ge};
         rcp_cnt_ff <= rcp_cnt_ff + RCP_CNT_W'(1);
         if (rcp_cnt_ff == RCP_CNT_W'(RCP_STEPS - 1)) begin
            rcp_busy_ff <= 1'b0;
            recip_ff    <= {rcp_quo_ff[RCP_W-2:0], rcp_ge} + RCP_W'(1);
         end
      end
   end

   // pipeline control
   logic [1:0]    fifo_cnt_ff;
   logic          en, accept;
   logic [NV-1:0] vld_ff;

   assign en        = fifo_cnt_ff != 2'd2;
   assign req_ready = en && !rcp_busy_ff;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[NV-2:0], accept};
   end

   // front stages: index clamp, normalized time, powers, shapes, products
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    clamp_in;
   logic [FRONT-1:0]        clamp_ff;
   logic [B_W-1:0]          prod_b;
   logic [S_W-1:0]          s_b_ff;
   logic [S_W-1:0]          s_c_ff, s2_c_ff;
   logic [S_W-1:0]          s_d_ff, s2_d_ff, s3_d_ff;
   logic [S_W-1:0]          s_e_ff, s2_e_ff, s3_e_ff, s4_e_ff;
   logic [S_W-1:0]          s_f_ff, s2_f_ff, s3_f_ff, s4_f_ff, s5_f_ff;
   logic signed [G_W-1:0]   e1, e2, e3, e4, e5, hp_in, hv_in, ha_in;
   logic signed [H_W-1:0]   hp_ff, hv_ff, ha_ff;
   logic signed [MP_W-1:0]  pp, pv, pa;
   logic signed [P_W-1:0]   ph_ff, vh_ff, ah_ff;

   always_comb begin
      idx_in   = req_sample_index;
      clamp_in = 1'b0;
      if ({1'b0, req_sample_index} >= count_ff) begin
         idx_in   = IDX_W'(count_ff - CNT_W'(1));
         clamp_in = 1'b1;
      end
   end

   assign prod_b = B_W'(idx_ff) * B_W'(recip_ff);

   assign e1 = signed'(G_W'(s_f_ff));
   assign e2 = signed'(G_W'(s2_f_ff));
   assign e3 = signed'(G_W'(s3_f_ff));
   assign e4 = signed'(G_W'(s4_f_ff));
   assign e5 = signed'(G_W'(s5_f_ff));
   assign hp_in = 36'sd6 * e5 - 36'sd15 * e4 + 36'sd10 * e3;
   assign hv_in = 36'sd30 * e4 - 36'sd60 * e3 + 36'sd30 * e2;
   assign ha_in = 36'sd120 * e3 - 36'sd180 * e2 + 36'sd60 * e1;

   assign pp = MP_W'(d_ff) * MP_W'(hp_ff);
   assign pv = MP_W'(d_ff) * MP_W'(hv_ff);
   assign pa = MP_W'(d_ff) * MP_W'(ha_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         idx_ff   <= idx_in;
         clamp_ff <= {clamp_ff[FRONT-2:0], clamp_in};
         s_b_ff   <= prod_b[RCP_SHIFT-SHAPE_FRAC +: S_W];
         s_c_ff   <= s_b_ff;
         s2_c_ff  <= qmul(s_b_ff, s_b_ff);
         s_d_ff   <= s_c_ff;
         s2_d_ff  <= s2_c_ff;
         s3_d_ff  <= qmul(s2_c_ff, s_c_ff);
         s_e_ff   <= s_d_ff;
         s2_e_ff  <= s2_d_ff;
         s3_e_ff  <= s3_d_ff;
         s4_e_ff  <= qmul(s3_d_ff, s_d_ff);
         s_f_ff   <= s_e_ff;
         s2_f_ff  <= s2_e_ff;
         s3_f_ff  <= s3_e_ff;
         s4_f_ff  <= s4_e_ff;
         s5_f_ff  <= qmul(s4_e_ff, s_e_ff);
         hp_ff    <= H_W'(hp_in);
         hv_ff    <= H_W'(hv_in);
         ha_ff    <= H_W'(ha_in);
         ph_ff    <= P_W'(pp >>> SHAPE_FRAC);
         vh_ff    <= P_W'(pv >>> SHAPE_FRAC);
         ah_ff    <= P_W'(pa >>> SHAPE_FRAC);
      end
   end

   // entry of the division chains: saturation tests and first remainders
   chain_type             chain_ff [0:CHAIN];
   chain_type             chain_in [0:CHAIN];
   chain_type             chain_head;
   logic signed [P_W:0]   pos_sum;
   logic [P_W-1:0]        vmag, amag;

   always_comb begin
      pos_sum = (P_W+1)'(start_ff) + (P_W+1)'(ph_ff);
      vmag    = vh_ff[P_W-1] ? P_W'(-vh_ff) : P_W'(vh_ff);
      amag    = ah_ff[P_W-1] ? P_W'(-ah_ff) : P_W'(ah_ff);

      chain_head.clamped = clamp_ff[FRONT-1];
      if (pos_sum > (P_W+1)'(SAT_MAX)) chain_head.position = SAT_MAX;
      else if (pos_sum < (P_W+1)'(SAT_MIN)) chain_head.position = SAT_MIN;
      else chain_head.position = pos_sum[31:0];
      chain_head.v_neg = vh_ff[P_W-1];
      chain_head.a_neg = ah_ff[P_W-1];
      // quotient reaches 2^31 exactly when |v1| >= tf*2^15, or 2|a1| >= tf^2
      chain_head.v_sat = 46'(vmag) >= {tf_ff, 15'd0};
      chain_head.a_sat = TFSQ_W'({amag, 1'b0}) >= tfsq_ff;
      chain_head.v_rem = TF_W'(vmag >> 15);
      chain_head.v_quo = {vmag[14:0], 16'd0};
      chain_head.a_rem = TF_W'(amag >> 18);
      chain_head.a_quo = {amag[17:0], 16'd0};
   end

   // one quotient bit per stage; acceleration divides twice by the duration
   always_comb begin
      logic [TF_W:0] vs, as;
      vs = '0;
      as = '0;
      chain_in[0] = chain_head;
      for (int k = 0; k < CHAIN; k++) begin
         chain_in[k+1] = chain_ff[k];
         if (k < DIV_BITS) begin
            vs = div_step(chain_ff[k].v_rem, chain_ff[k].v_quo[DIV_BITS-1], tf_ff);
            chain_in[k+1].v_rem = vs[TF_W-1:0];
            chain_in[k+1].v_quo = {chain_ff[k].v_quo[DIV_BITS-2:0], vs[TF_W]};
         end
         if (k < ADIV1_BITS) begin
            as = div_step(chain_ff[k].a_rem, chain_ff[k].a_quo[ADIV1_BITS-1], tf_ff);
            chain_in[k+1].a_rem = as[TF_W-1:0];
            chain_in[k+1].a_quo = {chain_ff[k].a_quo[ADIV1_BITS-2:0], as[TF_W]};
         end else if (k == ADIV1_BITS) begin
            // restart on q1*2^16 for the second division
            chain_in[k+1].a_rem = TF_W'(chain_ff[k].a_quo >> 15);
            chain_in[k+1].a_quo = ADIV1_BITS'({chain_ff[k].a_quo[14:0], 16'd0});
         end else begin
            as = div_step(chain_ff[k].a_rem, chain_ff[k].a_quo[DIV_BITS-1], tf_ff);
            chain_in[k+1].a_rem = as[TF_W-1:0];
            chain_in[k+1].a_quo = ADIV1_BITS'({chain_ff[k].a_quo[DIV_BITS-2:0], as[TF_W]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= CHAIN; k++) chain_ff[k] <= chain_in[k];
      end
   end

   // final result word
   result_type res_in;
   chain_type  last;

   always_comb begin
      last                 = chain_ff[CHAIN];
      res_in.position      = last.position;
      res_in.index_clamped = last.clamped;
      if (last.v_sat) res_in.velocity = last.v_neg ? SAT_MIN : SAT_MAX;
      else if (last.v_neg) res_in.velocity = 32'd0 - {1'b0, last.v_quo};
      else res_in.velocity = {1'b0, last.v_quo};
      if (last.a_sat) res_in.acceleration = last.a_neg ? SAT_MIN : SAT_MAX;
      else if (last.a_neg) res_in.acceleration = 32'd0 - {1'b0, last.a_quo[DIV_BITS-1:0]};
      else res_in.acceleration = {1'b0, last.a_quo[DIV_BITS-1:0]};
   end

   // two-word result buffer
   result_type fifo_ff [0:1];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic       push, pop;

   assign push = en && vld_ff[NV-1];
   assign pop  = (fifo_cnt_ff != 2'd0) && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         fifo_cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         fifo_cnt_ff <= fifo_cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) fifo_ff[wr_ptr_ff] <= res_in;
   end

   assign rsp_valid         = fifo_cnt_ff != 2'd0;
   assign rsp_position      = fifo_ff[rd_ptr_ff].position;
   assign rsp_velocity      = fifo_ff[rd_ptr_ff].velocity;
   assign rsp_acceleration  = fifo_ff[rd_ptr_ff].acceleration;
   assign rsp_index_clamped = fifo_ff[rd_ptr_ff].index_clamped;

endmodule

FILE: design/qts_checker.sv
// qts_checker: port-level checks of quintic_trajectory_sampler
// depends on qts_pkg; bound to the top level at the end of this file
module qts_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [qts_pkg::IDX_W-1:0]     req_sample_index,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [31:0]            rsp_position,
   input logic signed [31:0]            rsp_velocity,
   input logic signed [31:0]            rsp_acceleration,
   input logic                          rsp_index_clamped,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic [qts_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [31:0]                   csr_data
);
   import qts_pkg::*;

   // reciprocal rebuild must block requests right after reset
   a_reset_blocks_req: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req_ready high right after reset");

   a_reset_empties_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // any register write restarts the reciprocal
   a_csr_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("req_ready high right after a csr write");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position)
         && $stable(rsp_velocity) && $stable(rsp_acceleration)
         && $stable(rsp_index_clamped))
      else $error("stalled rsp word changed");

endmodule

bind quintic_trajectory_sampler qts_checker u_qts_checker (.*);
